// ----- rtl/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg: shared types, codes and helpers of the siren tone pattern generator
// Holds the pattern mode codes, indication codes, register indexes and the
// small decode functions used by the pipeline.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam int TIME_BITS_DEF = 32;

	// divider widths
	localparam int DIV1_RW = 17;  // pulse cycle may need 17 bits
	localparam int DIV2_RW = 16;  // sweep cycle fits 16 bits
	localparam int DIV2_QW = 14;  // sweep quotient stays below 2^13
	localparam int NUM_W   = DIV2_RW + DIV2_QW;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// pattern modes
	localparam logic [2:0] MODE_CONST = 3'd0;
	localparam logic [2:0] MODE_ALT   = 3'd1;
	localparam logic [2:0] MODE_PULSE = 3'd2;
	localparam logic [2:0] MODE_SOS   = 3'd3;
	localparam logic [2:0] MODE_SWEEP = 3'd4;
	localparam logic [2:0] MODE_TEST  = 3'd5;

	// indications
	localparam logic [2:0] IND_SOUND  = 3'd0;
	localparam logic [2:0] IND_SILENT = 3'd1;
	localparam logic [2:0] IND_FIRST  = 3'd2;
	localparam logic [2:0] IND_SECOND = 3'd3;
	localparam logic [2:0] IND_TEST   = 3'd4;

	// register indexes
	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_FREQ_A   = 3'd1;
	localparam logic [2:0] REG_FREQ_B   = 3'd2;
	localparam logic [2:0] REG_INTERVAL = 3'd3;
	localparam logic [2:0] REG_PULSE_ON = 3'd4;
	localparam logic [2:0] REG_PULSE_OFF= 3'd5;
	localparam logic [2:0] REG_TEST     = 3'd6;

	localparam logic [16:0] SOS_CYCLE_MS = 17'd4800;
	localparam logic [15:0] ALT_MIN_MS   = 16'd50;
	localparam logic [15:0] SWEEP_MIN_MS = 16'd100;
	localparam logic [13:0] MIN_TONE_HZ  = 14'd300;
	localparam logic [13:0] MAX_TONE_HZ  = 14'd2000;

	// side data that rides along the sweep divider
	typedef struct packed {
		logic [11:0] f_base;
		logic [2:0]  ind;
		logic        sweep;
		logic        neg;
	} stp_side_t;

	// marks of the sos cycle: 3 short, 3 long, 3 short, each with a 200 ms gap
	function automatic logic sos_on(input logic [12:0] ph);
		logic on;
		on = (ph < 13'd200)
			|| (ph >= 13'd400  && ph < 13'd600)
			|| (ph >= 13'd800  && ph < 13'd1000)
			|| (ph >= 13'd1200 && ph < 13'd1800)
			|| (ph >= 13'd2000 && ph < 13'd2600)
			|| (ph >= 13'd2800 && ph < 13'd3400)
			|| (ph >= 13'd3600 && ph < 13'd3800)
			|| (ph >= 13'd4000 && ph < 13'd4200)
			|| (ph >= 13'd4400 && ph < 13'd4600);
		return on;
	endfunction

	function automatic logic [10:0] clamp_tone(input logic [13:0] f);
		logic [13:0] r;
		if (f == 14'd0) begin
			r = 14'd0;
		end else if (f < MIN_TONE_HZ) begin
			r = MIN_TONE_HZ;
		end else if (f > MAX_TONE_HZ) begin
			r = MAX_TONE_HZ;
		end else begin
			r = f;
		end
		return r[10:0];
	endfunction

endpackage

// ----- rtl/stp_div_cell.sv -----
// ----------------------------------------------------------------------------
// stp_div_cell: one restoring division cell
// Takes one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the word.
// ----------------------------------------------------------------------------
module stp_div_cell #(
	parameter int RW = 17,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [RW-1:0] d,
	input  logic          vld_i,
	input  logic [RW-1:0] rem_i,
	input  logic [DW-1:0] word_i,
	output logic          vld_o,
	output logic [RW-1:0] rem_o,
	output logic [DW-1:0] word_o
);
	import stp_pkg::*;

	logic [RW:0]   r;
	logic [RW:0]   diff;
	logic          ge;
	logic          vld_q;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] word_q;

	assign r    = {rem_i, word_i[DW-1]};
	assign diff = r - {1'b0, d};
	assign ge   = (r >= {1'b0, d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[RW-1:0] : r[RW-1:0];
			word_q <= {word_i[DW-2:0], ge};
		end
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign word_o = word_q;

endmodule

// ----- rtl/siren_tone_pattern_generator_top.sv -----
// ----------------------------------------------------------------------------
// siren_tone_pattern_generator_top: siren tone pattern generator
// Maps elapsed milliseconds to a tone frequency and a phase indication.
// ----------------------------------------------------------------------------
// usage:
//  - input channel: in_valid / in_stall with elapsed_ms; a request is taken
//    at a clock edge with in_valid high and in_stall low
//  - output channel: out_valid / out_stall with freq_hz and indication
//  - config: cfg_we, cfg_index, cfg_data; write only while the block is idle
//  - one request enters every cycle unless in_stall is high; a request
//    passes TIME_BITS division cells for the pattern phase, three sweep
//    arithmetic stages, 14 sweep division cells and the output register
//  - the whole pipeline moves as one; when the output holds a result and
//    out_stall is high, every stage holds and in_stall goes high
//  - reset clears all valid bits and loads the register defaults
//    (constant mode, 1000 Hz / 1500 Hz, 500 ms, 200 ms on / 200 ms off)
//  - results leave in request order, exactly one per request
// ----------------------------------------------------------------------------
module siren_tone_pattern_generator_top #(
	parameter int TIME_BITS = stp_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [TIME_BITS-1:0]             elapsed_ms,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [10:0]                      freq_hz,
	output logic [2:0]                       indication,
	input  logic                             cfg_we,
	input  logic [stp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import stp_pkg::*;

	// configuration registers
	logic [2:0]  pattern_mode_q;
	logic [11:0] freq_a_q;
	logic [11:0] freq_b_q;
	logic [15:0] interval_q;
	logic [15:0] pulse_on_q;
	logic [15:0] pulse_off_q;
	logic        test_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q <= MODE_CONST;
			freq_a_q       <= 12'd1000;
			freq_b_q       <= 12'd1500;
			interval_q     <= 16'd500;
			pulse_on_q     <= 16'd200;
			pulse_off_q    <= 16'd200;
			test_mode_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      pattern_mode_q <= cfg_data[2:0];
				REG_FREQ_A:    freq_a_q       <= cfg_data[11:0];
				REG_FREQ_B:    freq_b_q       <= cfg_data[11:0];
				REG_INTERVAL:  interval_q     <= cfg_data;
				REG_PULSE_ON:  pulse_on_q     <= cfg_data;
				REG_PULSE_OFF: pulse_off_q    <= cfg_data;
				REG_TEST:      test_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: everything holds while a finished result waits
	logic en;
	logic out_valid_q;
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// divisors; user keeps them fixed while requests are in flight (not enforced)
	logic [16:0] pulse_cyc;
	logic [15:0] alt_iv;
	logic [15:0] sweep_c;
	logic [16:0] div1;

	assign pulse_cyc = {1'b0, pulse_on_q} + {1'b0, pulse_off_q};
	assign alt_iv    = (interval_q < ALT_MIN_MS) ? ALT_MIN_MS : interval_q;
	assign sweep_c   = (interval_q < SWEEP_MIN_MS) ? SWEEP_MIN_MS : interval_q;

	always_comb begin
		case (pattern_mode_q)
			MODE_ALT:   div1 = {1'b0, alt_iv};
			MODE_PULSE: div1 = (pulse_cyc == 17'd0) ? 17'd1 : pulse_cyc;
			MODE_SOS:   div1 = SOS_CYCLE_MS;
			default:    div1 = {1'b0, sweep_c};
		endcase
	end

	// phase divider: one cell per elapsed_ms bit
	logic                 c1_vld  [0:TIME_BITS];
	logic [DIV1_RW-1:0]   c1_rem  [0:TIME_BITS];
	logic [TIME_BITS-1:0] c1_word [0:TIME_BITS];

	assign c1_vld[0]  = in_valid;
	assign c1_rem[0]  = '0;
	assign c1_word[0] = elapsed_ms;

	for (genvar i = 0; i < TIME_BITS; i++) begin : g_c1
		stp_div_cell #(.RW(DIV1_RW), .DW(TIME_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(div1),
			.vld_i(c1_vld[i]), .rem_i(c1_rem[i]), .word_i(c1_word[i]),
			.vld_o(c1_vld[i+1]), .rem_o(c1_rem[i+1]), .word_o(c1_word[i+1])
		);
	end

	// stage 1: per-mode decode and sweep triangle position
	logic [DIV1_RW-1:0] rem1;
	logic               q0;
	logic [15:0]        p;
	logic               rising;
	logic [16:0]        t2;
	logic [15:0]        c_minus_p;
	stp_side_t          side_d;

	assign rem1      = c1_rem[TIME_BITS];
	assign q0        = c1_word[TIME_BITS][0];
	assign p         = rem1[15:0];
	assign rising    = (p < (sweep_c >> 1));
	assign c_minus_p = sweep_c - p;
	assign t2        = rising ? {p, 1'b0} : {c_minus_p, 1'b0};

	always_comb begin
		side_d.neg   = 1'b0;
		side_d.sweep = 1'b0;
		case (pattern_mode_q)
			MODE_CONST: begin
				side_d.f_base = freq_a_q;
				side_d.ind    = test_mode_q ? IND_TEST : IND_SOUND;
			end
			MODE_ALT: begin
				side_d.f_base = q0 ? freq_b_q : freq_a_q;
				side_d.ind    = q0 ? IND_SECOND : IND_FIRST;
			end
			MODE_PULSE: begin
				if (pulse_cyc == 17'd0 || rem1 < {1'b0, pulse_on_q}) begin
					side_d.f_base = freq_a_q;
					side_d.ind    = IND_SOUND;
				end else begin
					side_d.f_base = 12'd0;
					side_d.ind    = IND_SILENT;
				end
			end
			MODE_SOS: begin
				if (sos_on(rem1[12:0])) begin
					side_d.f_base = freq_a_q;
					side_d.ind    = IND_SOUND;
				end else begin
					side_d.f_base = 12'd0;
					side_d.ind    = IND_SILENT;
				end
			end
			MODE_TEST: begin
				side_d.f_base = freq_a_q;
				side_d.ind    = IND_TEST;
			end
			default: begin
				// sweep, and the undefined codes too
				side_d.f_base = 12'd0;
				side_d.ind    = rising ? IND_FIRST : IND_SECOND;
				side_d.sweep  = 1'b1;
			end
		endcase
	end

	logic        vld_s1;
	logic [16:0] t2_s1;
	stp_side_t   side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= c1_vld[TIME_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s1   <= t2;
			side_s1 <= side_d;
		end
	end

	// stage 2: a*c and (b-a)*t2
	logic signed [12:0] diff_ba;
	logic               vld_s2;
	logic [27:0]        pa_s2;
	logic signed [30:0] px_s2;
	stp_side_t          side_s2;

	assign diff_ba = $signed({1'b0, freq_b_q}) - $signed({1'b0, freq_a_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2   <= freq_a_q * sweep_c;
			px_s2   <= 31'(diff_ba * $signed({1'b0, t2_s1}));
			side_s2 <= side_s1;
		end
	end

	// stage 3: numerator and its sign
	logic signed [31:0] num;
	logic               vld_s3;
	logic [NUM_W-1:0]   num_s3;
	stp_side_t          side_n;
	stp_side_t          side_s3;

	assign num = $signed({4'b0, pa_s2}) + 32'(px_s2);

	// side data with the numerator sign folded in
	always_comb begin
		side_n     = side_s2;
		side_n.neg = num[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3  <= num[NUM_W-1:0];
			side_s3 <= side_n;
		end
	end

	// sweep divider: quotient is known to fit DIV2_QW bits
	logic               c2_vld  [0:DIV2_QW];
	logic [DIV2_RW-1:0] c2_rem  [0:DIV2_QW];
	logic [DIV2_QW-1:0] c2_word [0:DIV2_QW];
	stp_side_t          side_dl [0:DIV2_QW];

	assign c2_vld[0]  = vld_s3;
	assign c2_rem[0]  = num_s3[NUM_W-1:DIV2_QW];
	assign c2_word[0] = num_s3[DIV2_QW-1:0];
	assign side_dl[0] = side_s3;

	for (genvar j = 0; j < DIV2_QW; j++) begin : g_c2
		stp_div_cell #(.RW(DIV2_RW), .DW(DIV2_QW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(sweep_c),
			.vld_i(c2_vld[j]), .rem_i(c2_rem[j]), .word_i(c2_word[j]),
			.vld_o(c2_vld[j+1]), .rem_o(c2_rem[j+1]), .word_o(c2_word[j+1])
		);

		// side data travels next to the cells
		always_ff @(posedge clk) begin
			if (en) begin
				side_dl[j+1] <= side_dl[j];
			end
		end
	end

	// output register: pick, clamp
	stp_side_t   side_f;
	logic [13:0] f_sel;
	logic [10:0] freq_q;
	logic [2:0]  ind_q;

	assign side_f = side_dl[DIV2_QW];

	always_comb begin
		if (side_f.sweep) begin
			f_sel = side_f.neg ? 14'd0 : c2_word[DIV2_QW];
		end else begin
			f_sel = {2'b0, side_f.f_base};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c2_vld[DIV2_QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			freq_q <= clamp_tone(f_sel);
			ind_q  <= side_f.ind;
		end
	end

	assign out_valid  = out_valid_q;
	assign freq_hz    = freq_q;
	assign indication = ind_q;

`ifndef SYNTH
	// a sounding result is always inside the tone range
	a_tone_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (freq_hz == 11'd0 || (freq_hz >= 11'd300 && freq_hz <= 11'd2000)))
		else $error("tone outside 300..2000 Hz");

	// a silent phase never carries a tone
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && indication == IND_SILENT) |-> (freq_hz == 11'd0))
		else $error("silent phase with nonzero tone");

	// a stalled result stays on the output and is not dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");
`endif

endmodule
